[hdl/jsu_pkg.sv]
// shared types, codes and helpers for the json string unescaper
`timescale 1ns / 1ps

package jsu_pkg;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   // result status codes
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // text characters of interest
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;

   // continuation byte range codes of the utf-8 checker
   localparam logic [2:0] RNG_NORMAL = 3'd0;
   localparam logic [2:0] RNG_A0_BF  = 3'd1;
   localparam logic [2:0] RNG_80_9F  = 3'd2;
   localparam logic [2:0] RNG_90_BF  = 3'd3;
   localparam logic [2:0] RNG_80_8F  = 3'd4;

   // decode modes, one-hot
   typedef enum logic [7:0] {
      M_WAIT    = 8'b0000_0001,
      M_BODY    = 8'b0000_0010,
      M_ESC     = 8'b0000_0100,
      M_HEX     = 8'b0000_1000,
      M_PAIR_BS = 8'b0001_0000,
      M_PAIR_U  = 8'b0010_0000,
      M_LOW_HEX = 8'b0100_0000,
      M_HALT    = 8'b1000_0000
   } mode_type;

   // what closes a queued job after its bytes
   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_IDLE = 2'd1,
      TAIL_DONE = 2'd2,
      TAIL_ERR  = 2'd3
   } tail_type;

   // one queued job: up to four bytes and an optional status word
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      tail_type        tail;
   } entry_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } cp_enc_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] owed;
      logic [2:0] rng;
   } utf8_res_type;

   // utf-8 encoding of one code point
   function automatic cp_enc_type utf8_encode(input logic [20:0] cp);
      cp_enc_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.count    = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.count    = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.count    = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.count    = 3'd4;
      end
      return r;
   endfunction

endpackage

[hdl/json_string_unescape_top.sv]
// top level of the json string unescaper
`timescale 1ns / 1ps

// The req channel takes json text, one byte per word in req_tdata; a word with
// req_tuser set marks the end of the text and carries no byte. Blanks before an
// opening quote are skipped, the string body is unescaped (\uXXXX and surrogate
// pairs re-encoded as utf-8) and every emitted byte is checked as strict utf-8.
// The rsp channel gives one or more words per input word, the last with
// rsp_tlast: a decoded byte (has_byte set), or a status word with has_byte clear
// that says in progress, done (closing quote) or invalid. After invalid the
// block answers every word with invalid until reset.
// An accepted word passes the job queue and the output register before its
// first result word. The decoder takes one word per cycle; req_tready drops
// only when the queue is full. The result sequencer sends one word per cycle
// while rsp_tready is high, so a final hex digit that yields n utf-8 bytes
// takes n result words; the four-entry queue absorbs such bursts and receiver stalls.
// Reset is synchronous and active high: the block waits for an opening quote
// with the queue and output register empty.

module json_string_unescape_top import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] text_over
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] decoded_byte
   output logic [2:0] rsp_tuser,   // [0] has_byte, [2:1] status
   output logic       rsp_tlast    // run_last
);

   logic      q_push, q_ready, q_pop, q_valid;
   entry_type push_entry, head_entry;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (head_entry)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hdl/jsu_front.sv]
// front end: decodes one text byte per cycle into a queued job while the queue has room
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] text_over
   input  logic       q_ready,
   output logic       q_push,
   output entry_type  q_entry
);

   mode_type    mode_ff, mode_in;
   logic [1:0]  digits_ff, digits_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  hs_ff, hs_in;
   logic [1:0]  owed_ff, owed_in;
   logic [2:0]  rng_ff, rng_in;

   logic [7:0]   c;
   logic [4:0]   hexv;
   logic [15:0]  acc_new;
   logic [20:0]  cp_sel;
   cp_enc_type   enc;
   utf8_res_type utf;
   logic [7:0]   esc_val;
   logic         esc_ok;

   // hex digit value, bit 4 flags a valid digit
   function automatic logic [4:0] hex_value(input logic [7:0] ch);
      logic [4:0] r;
      r = '0;
      if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
      else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
      else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
      return r;
   endfunction

   // strict utf-8 check of one raw byte
   function automatic utf8_res_type utf8_step(input logic [1:0] owed, input logic [2:0] rng,
                                              input logic [7:0] b);
      logic [7:0]   lo;
      logic [7:0]   hi;
      utf8_res_type r;
      r.ok   = 1'b0;
      r.owed = owed;
      r.rng  = rng;
      lo     = 8'h80;
      hi     = 8'hBF;
      if (owed != 2'd0) begin
         case (rng)
            RNG_A0_BF: lo = 8'hA0;
            RNG_80_9F: hi = 8'h9F;
            RNG_90_BF: lo = 8'h90;
            RNG_80_8F: hi = 8'h8F;
            default:   lo = 8'h80;
         endcase
         if (b >= lo && b <= hi) begin
            r.ok   = 1'b1;
            r.owed = owed - 2'd1;
            r.rng  = RNG_NORMAL;
         end
      end else if (b < 8'h80) begin
         r.ok = 1'b1;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
         r.ok   = 1'b1;
         r.owed = 2'd1;
         r.rng  = RNG_NORMAL;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
         r.ok   = 1'b1;
         r.owed = 2'd2;
         r.rng  = (b == 8'hE0) ? RNG_A0_BF : (b == 8'hED) ? RNG_80_9F : RNG_NORMAL;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
         r.ok   = 1'b1;
         r.owed = 2'd3;
         r.rng  = (b == 8'hF0) ? RNG_90_BF : (b == 8'hF4) ? RNG_80_8F : RNG_NORMAL;
      end
      return r;
   endfunction

   assign c          = req_tdata;
   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;

   // helpers shared by the mode arms
   assign hexv    = hex_value(c);
   assign acc_new = {acc_ff[11:0], hexv[3:0]};
   assign cp_sel  = (mode_ff == M_LOW_HEX) ?
                    {11'({1'b0, hs_ff} + 11'h040), acc_new[9:0]} : {5'd0, acc_new};
   assign enc     = utf8_encode(cp_sel);
   assign utf     = utf8_step(owed_ff, rng_ff, c);

   // simple escape letters
   always_comb begin
      esc_ok  = 1'b1;
      esc_val = c;
      unique case (c)
         CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = c;
         CH_LOW_B: esc_val = CH_BS;
         CH_LOW_F: esc_val = CH_FF;
         CH_LOW_N: esc_val = CH_LF;
         CH_LOW_R: esc_val = CH_CR;
         CH_LOW_T: esc_val = CH_TAB;
         default:  esc_ok  = 1'b0;
      endcase
   end

   // decode one word
   always_comb begin
      mode_in        = mode_ff;
      digits_in      = digits_ff;
      acc_in         = acc_ff;
      hs_in          = hs_ff;
      owed_in        = owed_ff;
      rng_in         = rng_ff;
      q_entry.bytes  = '0;
      q_entry.nbytes = 3'd0;
      q_entry.tail   = TAIL_IDLE;
      if (mode_ff == M_HALT || req_tuser) begin
         mode_in      = M_HALT;
         q_entry.tail = TAIL_ERR;
      end else begin
         unique case (mode_ff)
            M_WAIT: begin
               if (c == CH_QUOTE) begin
                  mode_in   = M_BODY;
                  digits_in = 2'd0;
                  acc_in    = '0;
                  hs_in     = '0;
                  owed_in   = 2'd0;
                  rng_in    = RNG_NORMAL;
               end else if (!(c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR)) begin
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end
            end
            M_BODY: begin
               if (c == CH_QUOTE) begin
                  if (owed_ff != 2'd0) begin
                     mode_in      = M_HALT;
                     q_entry.tail = TAIL_ERR;
                  end else begin
                     mode_in      = M_WAIT;
                     q_entry.tail = TAIL_DONE;
                     digits_in    = 2'd0;
                     acc_in       = '0;
                     hs_in        = '0;
                     owed_in      = 2'd0;
                     rng_in       = RNG_NORMAL;
                  end
               end else if (c < CH_SPACE) begin
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end else if (c == CH_BSLASH) begin
                  mode_in = M_ESC;
               end else if (utf.ok) begin
                  owed_in          = utf.owed;
                  rng_in           = utf.rng;
                  q_entry.bytes[0] = c;
                  q_entry.nbytes   = 3'd1;
                  q_entry.tail     = TAIL_NONE;
               end else begin
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end
            end
            M_ESC: begin
               if (c == CH_LOW_U) begin
                  mode_in   = M_HEX;
                  digits_in = 2'd0;
                  acc_in    = '0;
               end else if (!esc_ok || owed_ff != 2'd0) begin
                  // a decoded ascii byte cannot sit inside an open sequence
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end else begin
                  mode_in          = M_BODY;
                  q_entry.bytes[0] = esc_val;
                  q_entry.nbytes   = 3'd1;
                  q_entry.tail     = TAIL_NONE;
               end
            end
            M_PAIR_BS: begin
               if (c == CH_BSLASH) begin
                  mode_in = M_PAIR_U;
               end else begin
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end
            end
            M_PAIR_U: begin
               if (c == CH_LOW_U) begin
                  mode_in   = M_LOW_HEX;
                  digits_in = 2'd0;
                  acc_in    = '0;
               end else begin
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end
            end
            M_HEX, M_LOW_HEX: begin
               if (!hexv[4]) begin
                  mode_in      = M_HALT;
                  q_entry.tail = TAIL_ERR;
               end else if (digits_ff != 2'd3) begin
                  digits_in = digits_ff + 2'd1;
                  acc_in    = acc_new;
               end else begin
                  digits_in = 2'd0;
                  acc_in    = '0;
                  if (mode_ff == M_HEX && acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                     // high surrogate, wait for its partner
                     hs_in   = acc_new[9:0];
                     mode_in = M_PAIR_BS;
                  end else if ((mode_ff == M_HEX) == (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF))
                  begin
                     // lone low surrogate, or a pair whose second half is not low
                     mode_in      = M_HALT;
                     q_entry.tail = TAIL_ERR;
                  end else if (owed_ff != 2'd0) begin
                     // lead byte lands inside an open raw sequence
                     mode_in      = M_HALT;
                     q_entry.tail = TAIL_ERR;
                  end else begin
                     // encoded bytes form a complete well-formed sequence
                     mode_in        = M_BODY;
                     hs_in          = '0;
                     q_entry.bytes  = enc.bytes;
                     q_entry.nbytes = enc.count;
                     q_entry.tail   = TAIL_NONE;
                  end
               end
            end
            default: begin
               mode_in      = M_HALT;
               q_entry.tail = TAIL_ERR;
            end
         endcase
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_WAIT;
         digits_ff <= 2'd0;
         acc_ff    <= '0;
         hs_ff     <= '0;
         owed_ff   <= 2'd0;
         rng_ff    <= RNG_NORMAL;
      end else if (q_push) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
         hs_ff     <= hs_in;
         owed_ff   <= owed_in;
         rng_ff    <= rng_in;
      end
   end

endmodule

[hdl/jsu_queue.sv]
// short job queue between the decoder and the result sequencer
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      push_ready,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign push_ready = (cnt_ff != (QPTR_W+1)'(QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !(pop && pop_valid)) cnt_in = cnt_ff + 1'b1;
      else if (!push && pop && pop_valid) cnt_in = cnt_ff - 1'b1;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && pop_valid) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[hdl/jsu_back.sv]
// back end: turns each queued job into result words, one per cycle while the receiver is ready
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_entry,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] decoded_byte
   output logic [2:0] rsp_tuser,   // [0] has_byte, [2:1] status
   output logic       rsp_tlast    // run_last
);

   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff;

   logic       load;
   logic [2:0] total;

   assign load  = q_valid && (!valid_ff || rsp_tready);
   assign total = q_entry.nbytes + {2'd0, (q_entry.tail != TAIL_NONE)};
   assign q_pop = load && last_in;

   // pick the current word of the head job
   always_comb begin
      last_in = ({1'b0, idx_ff} == total - 3'd1);
      if ({1'b0, idx_ff} < q_entry.nbytes) begin
         byte_in   = q_entry.bytes[idx_ff];
         has_in    = 1'b1;
         status_in = ST_BUSY;
      end else begin
         byte_in = 8'd0;
         has_in  = 1'b0;
         case (q_entry.tail)
            TAIL_DONE: status_in = ST_DONE;
            TAIL_ERR:  status_in = ST_BAD;
            default:   status_in = ST_BUSY;
         endcase
      end
   end

   // output register and word index
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= last_in ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         has_ff    <= has_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {status_ff, has_ff};
   assign rsp_tlast  = last_ff;

endmodule
